// ===== rtl/akiu_pkg.sv =====
// ============================================================================
// akiu_pkg: shared types and constants of the adaptive keep-alive interval unit
// Holds the event, report and mode codes, register reset values and the
// packed structs for configuration, input item, learner state and result.
// ============================================================================
`default_nettype none

package akiu_pkg;

    // Field widths
    localparam int unsigned IVL_W   = 22;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned ADDR_W  = 3;

    // Consecutive short failures that flag a bad network
    localparam logic [CNT_W-1:0] BAD_NET_LIMIT = 8'd6;
    // Lateness of a probe that counts as a doze vote, in ms
    localparam logic [TIME_W:0]  DOZE_TOL_MS   = 33'd20000;
    // Doze votes needed before the doze vote can win
    localparam logic [CNT_W-1:0] DOZE_MIN_VOTES = 8'd2;

    // Event codes
    typedef enum logic [2:0] {
        REQ_PROBE_SENT = 3'd0,
        REQ_RESULT     = 3'd1,
        REQ_INTERVAL   = 3'd2,
        REQ_LINK_UP    = 3'd3,
        REQ_LINK_DOWN  = 3'd4,
        REQ_DOZE_CHECK = 3'd5
    } req_t;

    // Report codes
    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_DISCONNECT = 3'd1,
        ACT_BAD_NET    = 3'd2,
        ACT_RECALC     = 3'd3,
        ACT_CALC_END   = 3'd4
    } action_t;

    // Learned interval mode
    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_SMART = 2'd1,
        MODE_DOZE  = 2'd2
    } mode_t;

    // Configuration register indexes
    typedef enum logic [ADDR_W-1:0] {
        REG_MIN_INTERVAL  = 3'd0,
        REG_MAX_INTERVAL  = 3'd1,
        REG_SUCCESS_STEP  = 3'd2,
        REG_HEART_STEP    = 3'd3,
        REG_STABLE_TEST   = 3'd4,
        REG_BASE_SUCCESS  = 3'd5,
        REG_MAX_FAIL      = 3'd6,
        REG_PROBE_AGE     = 3'd7
    } reg_idx_t;

    // Register reset values
    localparam logic [IVL_W-1:0]  MIN_INTERVAL_RST  = 22'd270000;
    localparam logic [IVL_W-1:0]  MAX_INTERVAL_RST  = 22'd1710000;
    localparam logic [IVL_W-1:0]  SUCCESS_STEP_RST  = 22'd20000;
    localparam logic [IVL_W-1:0]  HEART_STEP_RST    = 22'd60000;
    localparam logic [CNT_W-1:0]  STABLE_TEST_RST   = 8'd3;
    localparam logic [CNT_W-1:0]  BASE_SUCCESS_RST  = 8'd3;
    localparam logic [CNT_W-1:0]  MAX_FAIL_RST      = 8'd3;
    localparam logic [TIME_W-1:0] PROBE_AGE_RST     = 32'd604800;

    typedef struct packed {
        logic [IVL_W-1:0]  min_interval;
        logic [IVL_W-1:0]  max_interval;
        logic [IVL_W-1:0]  success_step;
        logic [IVL_W-1:0]  heart_step;
        logic [CNT_W-1:0]  stable_test_count;
        logic [CNT_W-1:0]  base_success_count;
        logic [CNT_W-1:0]  max_fail_count;
        logic [TIME_W-1:0] probe_age_seconds;
    } cfg_t;

    typedef struct packed {
        logic [2:0]        req_type;
        logic              success;
        logic              timed_out;
        logic [TIME_W-1:0] now_seconds;
        logic              app_active;
        logic              net_connected;
        logic              on_mobile;
        logic [TIME_W-1:0] elapsed_ms;
    } item_t;

    typedef struct packed {
        logic              waiting_response;
        logic [CNT_W-1:0]  link_success_count;
        logic [IVL_W-1:0]  last_interval;
        logic [IVL_W-1:0]  prev_interval;
        logic [IVL_W-1:0]  cycle_interval;
        logic [IVL_W-1:0]  learned_interval;
        logic [CNT_W-1:0]  learned_success_count;
        logic [CNT_W-1:0]  learned_fail_count;
        logic [CNT_W-1:0]  short_fail_count;
        logic              learned_stable;
        mode_t             learned_mode;
        logic [TIME_W-1:0] last_change_time;
        logic [CNT_W-1:0]  doze_votes;
        logic [CNT_W-1:0]  normal_votes;
        logic              probe_started;
    } state_t;

    typedef struct packed {
        logic [IVL_W-1:0] interval;
        action_t          report_action;
        logic             report_flag;
        logic             stable;
        mode_t            heart_mode;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/akiu_core.sv =====
// ============================================================================
// akiu_core: next-state and result logic of the keep-alive learner
// Takes the current learner state, the configuration and one event and
// produces the state after the event and the result item, in one pass.
// ============================================================================
`default_nettype none

module akiu_core (
    input  akiu_pkg::cfg_t    cfg,
    input  akiu_pkg::state_t  st,
    input  akiu_pkg::item_t   item,
    output akiu_pkg::state_t  nx,
    output akiu_pkg::result_t res
);

    // Saturating 8-bit increment
    function automatic logic [akiu_pkg::CNT_W-1:0] inc8(input logic [akiu_pkg::CNT_W-1:0] v);
        inc8 = (v == '1) ? v : v + 8'd1;
    endfunction

    logic [akiu_pkg::IVL_W-1:0]  top;
    logic                        doze;
    logic                        res_ok;
    logic                        res_tmo;
    logic [akiu_pkg::TIME_W:0]   age;
    logic                        age_ok;
    logic [akiu_pkg::IVL_W:0]    raised;
    logic [akiu_pkg::IVL_W+1:0]  backed;
    logic                        backed_ok;
    logic [akiu_pkg::TIME_W:0]   lag;
    logic [akiu_pkg::TIME_W:0]   lag_mag;
    logic                        late;
    logic [akiu_pkg::IVL_W-1:0]  li;
    logic [akiu_pkg::IVL_W-1:0]  ln;
    logic                        touch_time;
    akiu_pkg::action_t           act;
    logic                        flg;

    // Ceiling, doze vote and shared compares
    assign top    = (cfg.max_interval > cfg.success_step) ?
                    cfg.max_interval - cfg.success_step : '0;
    assign doze   = (st.doze_votes >= akiu_pkg::DOZE_MIN_VOTES) &&
                    ({1'b0, st.doze_votes} > {st.normal_votes, 1'b0});
    assign res_ok  = (item.req_type == akiu_pkg::REQ_RESULT) && item.success;
    assign res_tmo = (item.req_type == akiu_pkg::REQ_RESULT) && item.timed_out;
    assign age    = {1'b0, item.now_seconds} - {1'b0, st.last_change_time};
    assign age_ok = !age[akiu_pkg::TIME_W] &&
                    (age[akiu_pkg::TIME_W-1:0] >= cfg.probe_age_seconds);
    assign raised = {1'b0, st.learned_interval} + {1'b0, cfg.heart_step};
    assign backed = {2'b00, st.learned_interval} - {2'b00, cfg.heart_step}
                    - {2'b00, cfg.success_step};
    assign backed_ok = !backed[akiu_pkg::IVL_W+1] &&
                       (backed[akiu_pkg::IVL_W:0] > {1'b0, cfg.min_interval});
    assign lag     = {1'b0, item.elapsed_ms} -
                     {{(akiu_pkg::TIME_W+1-akiu_pkg::IVL_W){1'b0}}, st.last_interval};
    assign lag_mag = lag[akiu_pkg::TIME_W] ? (~lag + 33'd1) : lag;
    assign late    = lag_mag >= akiu_pkg::DOZE_TOL_MS;

    // Apply one event to the learner state
    always_comb
    begin
        nx         = st;
        act        = akiu_pkg::ACT_NONE;
        flg        = 1'b0;
        li         = st.learned_interval;
        ln         = st.learned_interval;
        touch_time = 1'b0;
        case (item.req_type) inside
            akiu_pkg::REQ_PROBE_SENT:
            begin
                nx.probe_started    = 1'b1;
                nx.waiting_response = 1'b1;
            end
            akiu_pkg::REQ_RESULT, akiu_pkg::REQ_LINK_DOWN:
            begin
                if (st.waiting_response)
                begin
                    // Disconnect report on a failure of a stable link
                    if (!res_ok && st.link_success_count >= cfg.stable_test_count &&
                        st.learned_stable)
                    begin
                        act = akiu_pkg::ACT_DISCONNECT;
                        flg = res_tmo;
                    end
                    nx.prev_interval    = st.cycle_interval;
                    nx.cycle_interval   = st.last_interval;
                    nx.waiting_response = 1'b0;
                    if (res_ok)
                        nx.link_success_count = inc8(st.link_success_count);
                    if (nx.link_success_count <= cfg.stable_test_count)
                    begin
                        // Link still settling: count short failures
                        nx.short_fail_count = res_ok ? '0 : inc8(st.short_fail_count);
                        if (nx.short_fail_count >= akiu_pkg::BAD_NET_LIMIT &&
                            item.net_connected)
                        begin
                            act = akiu_pkg::ACT_BAD_NET;
                            flg = 1'b0;
                            nx.short_fail_count = '0;
                        end
                    end
                    else if (st.last_interval == st.learned_interval)
                    begin
                        // Count the outcome against the learned value
                        if (res_ok)
                        begin
                            if (st.last_interval == nx.prev_interval)
                            begin
                                nx.learned_success_count = inc8(st.learned_success_count);
                                nx.learned_fail_count    = '0;
                            end
                        end
                        else
                        begin
                            if (res_tmo)
                                nx.learned_success_count = '0;
                            nx.learned_fail_count = inc8(st.learned_fail_count);
                        end

                        if (res_ok && st.learned_stable)
                        begin
                            // Probe a larger interval once the stable value is old
                            if (st.learned_interval < top && age_ok)
                            begin
                                nx.learned_interval      = st.learned_interval +
                                                           cfg.success_step;
                                nx.learned_success_count = '0;
                                nx.learned_stable        = 1'b0;
                                nx.learned_fail_count    = '0;
                                act                      = akiu_pkg::ACT_RECALC;
                                flg                      = 1'b0;
                                touch_time               = 1'b1;
                            end
                        end
                        else if (res_ok)
                        begin
                            touch_time = 1'b1;
                            // Raise after enough successes in a row
                            if (nx.learned_success_count >= cfg.base_success_count)
                            begin
                                nx.learned_success_count = '0;
                                if (st.learned_interval >= top)
                                begin
                                    nx.learned_interval = top;
                                    nx.learned_stable   = 1'b1;
                                    nx.learned_mode     = doze ? akiu_pkg::MODE_DOZE :
                                                                 akiu_pkg::MODE_SMART;
                                    act                 = akiu_pkg::ACT_CALC_END;
                                    flg                 = 1'b0;
                                end
                                else if (doze)
                                    nx.learned_interval = top;
                                else if (raised < {1'b0, top})
                                    nx.learned_interval = raised[akiu_pkg::IVL_W-1:0];
                                else
                                    nx.learned_interval = top;
                            end
                        end
                        else if (st.last_interval != cfg.min_interval)
                        begin
                            touch_time = 1'b1;
                            // Back off after enough failures
                            if (nx.learned_fail_count >= cfg.max_fail_count)
                            begin
                                nx.learned_success_count = '0;
                                nx.learned_fail_count    = '0;
                                if (st.learned_stable)
                                begin
                                    nx.learned_interval = cfg.min_interval;
                                    nx.learned_stable   = 1'b0;
                                    act                 = akiu_pkg::ACT_RECALC;
                                    flg                 = 1'b1;
                                end
                                else
                                begin
                                    if (!doze && backed_ok)
                                        nx.learned_interval = backed[akiu_pkg::IVL_W-1:0];
                                    else
                                        nx.learned_interval = cfg.min_interval;
                                    nx.learned_stable = 1'b1;
                                    nx.learned_mode   = doze ? akiu_pkg::MODE_DOZE :
                                                               akiu_pkg::MODE_SMART;
                                    act               = akiu_pkg::ACT_CALC_END;
                                    flg               = 1'b0;
                                end
                            end
                        end
                    end
                    if (touch_time)
                        nx.last_change_time = item.now_seconds;
                end
                // Link down also drops the success run
                if (item.req_type == akiu_pkg::REQ_LINK_DOWN)
                begin
                    nx.learned_success_count = '0;
                    if (nx.learned_stable)
                        nx.last_interval = cfg.min_interval;
                end
            end
            akiu_pkg::REQ_INTERVAL:
            begin
                if (item.app_active || st.link_success_count < cfg.stable_test_count)
                    nx.last_interval = cfg.min_interval;
                else
                begin
                    if (doze && st.learned_mode != akiu_pkg::MODE_DOZE &&
                        st.learned_interval != top)
                    begin
                        li = cfg.min_interval;
                        ln = cfg.min_interval;
                    end
                    if (li >= cfg.max_interval || li < cfg.min_interval)
                    begin
                        li = cfg.min_interval;
                        ln = cfg.min_interval;
                    end
                    nx.last_interval    = li;
                    nx.learned_interval = ln;
                end
            end
            akiu_pkg::REQ_LINK_UP:
            begin
                nx.link_success_count = '0;
                nx.prev_interval      = cfg.min_interval;
                nx.cycle_interval     = cfg.min_interval;
            end
            akiu_pkg::REQ_DOZE_CHECK:
            begin
                if (!item.app_active && st.probe_started && item.on_mobile)
                begin
                    // Vote on how late the probe fired
                    if (late)
                    begin
                        nx.doze_votes = inc8(st.doze_votes);
                        if (st.normal_votes != '0)
                            nx.normal_votes = st.normal_votes - 8'd1;
                    end
                    else
                    begin
                        nx.normal_votes = inc8(st.normal_votes);
                        if (st.doze_votes != '0)
                            nx.doze_votes = st.doze_votes - 8'd1;
                    end
                    nx.probe_started = 1'b0;
                end
            end
            default:
            begin
                nx = st;
            end
        endcase
    end

    // Result item
    assign res.interval      = nx.last_interval;
    assign res.report_action = act;
    assign res.report_flag   = flg;
    assign res.stable        = nx.learned_stable;
    assign res.heart_mode    = nx.learned_mode;

endmodule

`default_nettype wire

// ===== rtl/adaptive_keepalive_interval_unit.sv =====
// ============================================================================
// adaptive_keepalive_interval_unit: keep-alive interval learner
// Learns the longest safe idle interval of a link from probe outcomes and
// reports disconnect, bad network, recalculation and end of learning.
// ============================================================================
`default_nettype none

// Every input transfer yields exactly one output transfer. An event is taken
// into an input register, applied to the learner state by combinational logic
// and its result lands in the output register, so the unit sustains one event
// per clock; the only limit is the output side taking results. The user must
// write configuration registers through the cfg port only while no event is in
// flight; the unit does not enforce this. Writes take effect for the next event.

module adaptive_keepalive_interval_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [31:0] cfg_data,
    // Event stream
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // [0] success, [1] timed_out, [33:2] now_seconds, [34] app_active,
    // [35] net_connected, [36] on_mobile, [68:37] elapsed_ms, [71:69] zero
    input  wire logic [71:0] s_axis_tdata,
    // [2:0] req_type
    input  wire logic [2:0]  s_axis_tuser,
    // Result stream
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [21:0] interval, [24:22] report_action, [25] report_flag, [26] stable,
    // [28:27] heart_mode, [31:29] zero
    output      logic [31:0] m_axis_tdata
);

    akiu_pkg::cfg_t    cfg_reg;
    akiu_pkg::state_t  state_reg;
    akiu_pkg::state_t  state_next;
    akiu_pkg::item_t   item_reg;
    akiu_pkg::item_t   item_in;
    akiu_pkg::result_t res_reg;
    akiu_pkg::result_t res_next;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              advance;

    // Unpack the incoming transfer
    assign item_in.req_type      = s_axis_tuser;
    assign item_in.success       = s_axis_tdata[0];
    assign item_in.timed_out     = s_axis_tdata[1];
    assign item_in.now_seconds   = s_axis_tdata[33:2];
    assign item_in.app_active    = s_axis_tdata[34];
    assign item_in.net_connected = s_axis_tdata[35];
    assign item_in.on_mobile     = s_axis_tdata[36];
    assign item_in.elapsed_ms    = s_axis_tdata[68:37];

    // Advance the held event when the output register can take its result
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_interval       <= akiu_pkg::MIN_INTERVAL_RST;
            cfg_reg.max_interval       <= akiu_pkg::MAX_INTERVAL_RST;
            cfg_reg.success_step       <= akiu_pkg::SUCCESS_STEP_RST;
            cfg_reg.heart_step         <= akiu_pkg::HEART_STEP_RST;
            cfg_reg.stable_test_count  <= akiu_pkg::STABLE_TEST_RST;
            cfg_reg.base_success_count <= akiu_pkg::BASE_SUCCESS_RST;
            cfg_reg.max_fail_count     <= akiu_pkg::MAX_FAIL_RST;
            cfg_reg.probe_age_seconds  <= akiu_pkg::PROBE_AGE_RST;
        end
        else if (cfg_we)
        begin
            unique case (akiu_pkg::reg_idx_t'(cfg_addr))
                akiu_pkg::REG_MIN_INTERVAL: cfg_reg.min_interval       <= cfg_data[21:0];
                akiu_pkg::REG_MAX_INTERVAL: cfg_reg.max_interval       <= cfg_data[21:0];
                akiu_pkg::REG_SUCCESS_STEP: cfg_reg.success_step       <= cfg_data[21:0];
                akiu_pkg::REG_HEART_STEP:   cfg_reg.heart_step         <= cfg_data[21:0];
                akiu_pkg::REG_STABLE_TEST:  cfg_reg.stable_test_count  <= cfg_data[7:0];
                akiu_pkg::REG_BASE_SUCCESS: cfg_reg.base_success_count <= cfg_data[7:0];
                akiu_pkg::REG_MAX_FAIL:     cfg_reg.max_fail_count     <= cfg_data[7:0];
                akiu_pkg::REG_PROBE_AGE:    cfg_reg.probe_age_seconds  <= cfg_data;
                default:                    cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            item_reg <= item_in;
    end

    // Event logic
    akiu_core u_core (
        .cfg  (cfg_reg),
        .st   (state_reg),
        .item (item_reg),
        .nx   (state_next),
        .res  (res_next)
    );

    // Learner state: commit on each advanced event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.waiting_response      <= 1'b0;
            state_reg.link_success_count    <= '0;
            state_reg.last_interval         <= akiu_pkg::MIN_INTERVAL_RST;
            state_reg.prev_interval         <= akiu_pkg::MIN_INTERVAL_RST;
            state_reg.cycle_interval        <= akiu_pkg::MIN_INTERVAL_RST;
            state_reg.learned_interval      <= akiu_pkg::MIN_INTERVAL_RST;
            state_reg.learned_success_count <= '0;
            state_reg.learned_fail_count    <= '0;
            state_reg.short_fail_count      <= '0;
            state_reg.learned_stable        <= 1'b0;
            state_reg.learned_mode          <= akiu_pkg::MODE_NONE;
            state_reg.last_change_time      <= '0;
            state_reg.doze_votes            <= '0;
            state_reg.normal_votes          <= '0;
            state_reg.probe_started         <= 1'b0;
        end
        else if (advance)
            state_reg <= state_next;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    // Pack the outgoing transfer
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, res_reg.heart_mode, res_reg.stable,
                            res_reg.report_flag, res_reg.report_action,
                            res_reg.interval};

    // A stable learned value always carries a mode
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.learned_stable |-> (state_reg.learned_mode != akiu_pkg::MODE_NONE))
        else $error("stable value without a mode");

    // A probe-sent event leaves the learner waiting for its result
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.req_type == akiu_pkg::REQ_PROBE_SENT)
        |=> (state_reg.waiting_response && state_reg.probe_started))
        else $error("probe sent did not arm the response wait");

    // An interval request from a foreground app grants the floor
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.req_type == akiu_pkg::REQ_INTERVAL && item_reg.app_active)
        |=> (res_reg.interval == $past(cfg_reg.min_interval)))
        else $error("foreground request did not get the smallest interval");

    // No report means no report flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.report_action == akiu_pkg::ACT_NONE)
        |-> !res_reg.report_flag)
        else $error("report flag without a report");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ============================================================================
// tb: testbench of the adaptive keep-alive interval unit
// Drives event transfers with bursts and gaps, throttles the result stream,
// and compares every result with a cycle-free model of the learner that is
// kept in step with each accepted event. Configuration is reloaded between
// phases, from register extremes to random settings.
// ============================================================================
`default_nettype none

module tb;

    // Event codes with no defined meaning
    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;

    // Learner constants
    localparam int unsigned BAD_NET_RUN    = 6;
    localparam longint      DOZE_SLACK_MS  = 20000;
    localparam int unsigned DOZE_QUORUM    = 2;

    // Register values after reset
    localparam logic [21:0] MIN_IVL_INIT    = 22'd270000;
    localparam logic [21:0] MAX_IVL_INIT    = 22'd1710000;
    localparam logic [21:0] SUCCESS_INIT    = 22'd20000;
    localparam logic [21:0] HEART_INIT      = 22'd60000;
    localparam logic [7:0]  COUNT_INIT      = 8'd3;
    localparam logic [31:0] PROBE_AGE_INIT  = 32'd604800;

    localparam int unsigned ITEM_TARGET = 1300;
    localparam int unsigned CYCLE_LIMIT = 500000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [31:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [0] success, [1] timed_out, [33:2] now_seconds, [34] app_active,
    // [35] net_connected, [36] on_mobile, [68:37] elapsed_ms, [71:69] zero
    logic [71:0] s_axis_tdata = '0;
    // [2:0] req_type
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [21:0] interval, [24:22] report_action, [25] report_flag, [26] stable,
    // [28:27] heart_mode, [31:29] zero
    logic [31:0] m_axis_tdata;

    // Model copy of the registers and of the learner
    akiu_pkg::cfg_t    regs;
    logic              wait_resp;
    logic [7:0]        link_ok_cnt;
    logic [21:0]       cur_ivl;
    logic [21:0]       prev_ivl;
    logic [21:0]       cyc_ivl;
    logic [21:0]       learn_ivl;
    logic [7:0]        learn_ok_cnt;
    logic [7:0]        learn_fail_cnt;
    logic [7:0]        short_fail_cnt;
    logic              learn_stable;
    akiu_pkg::mode_t   learn_mode;
    logic [31:0]       change_time;
    logic [7:0]        doze_cnt;
    logic [7:0]        normal_cnt;
    logic              probe_armed;
    akiu_pkg::action_t note_act;
    logic              note_flag;

    akiu_pkg::result_t due_outcomes[$];
    int unsigned errors = 0;
    int unsigned events_sent = 0;
    int unsigned burst_left = 0;
    int unsigned cycle_count = 0;
    logic [31:0] clock_s = 32'd1000;
    logic [31:0] stall_pat = '1;
    int unsigned stall_left = 0;

    adaptive_keepalive_interval_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // Learner model
    // ------------------------------------------------------------------------

    function automatic logic [7:0] sat_inc(logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    // Ceiling stops at zero when the step exceeds the maximum
    function automatic logic [21:0] ivl_ceiling();
        return (regs.max_interval > regs.success_step) ?
               regs.max_interval - regs.success_step : '0;
    endfunction

    function automatic bit doze_wins();
        return doze_cnt >= DOZE_QUORUM && {1'b0, doze_cnt} > {normal_cnt, 1'b0};
    endfunction

    // Apply a probe outcome; a later report overrides an earlier one
    function automatic void settle_probe(bit ok, bit tmo, logic [31:0] now, bit conn);
        logic [21:0] top;
        logic [22:0] raised;
        longint      age;
        longint      age_lim;
        longint      trimmed;
        longint      part;
        longint      floor_v;
        top = ivl_ceiling();
        if (!wait_resp)
            return;
        if (!ok && link_ok_cnt >= regs.stable_test_count && learn_stable)
        begin
            note_act = akiu_pkg::ACT_DISCONNECT;
            note_flag = tmo;
        end
        prev_ivl = cyc_ivl;
        cyc_ivl = cur_ivl;
        wait_resp = 1'b0;
        if (ok)
            link_ok_cnt = sat_inc(link_ok_cnt);
        // Young link: only track a run of short failures
        if (link_ok_cnt <= regs.stable_test_count)
        begin
            short_fail_cnt = ok ? 8'd0 : sat_inc(short_fail_cnt);
            if (short_fail_cnt >= BAD_NET_RUN && conn)
            begin
                note_act = akiu_pkg::ACT_BAD_NET;
                note_flag = 1'b0;
                short_fail_cnt = '0;
            end
            return;
        end
        if (cur_ivl != learn_ivl)
            return;
        if (ok)
        begin
            if (cur_ivl == prev_ivl)
            begin
                learn_ok_cnt = sat_inc(learn_ok_cnt);
                learn_fail_cnt = '0;
            end
        end
        else
        begin
            if (tmo)
                learn_ok_cnt = '0;
            learn_fail_cnt = sat_inc(learn_fail_cnt);
        end
        // Stable value: probe upward once it is old enough
        if (ok && learn_stable)
        begin
            if (learn_ivl >= top)
                return;
            age = now;
            age_lim = change_time;
            age = age - age_lim;
            age_lim = regs.probe_age_seconds;
            if (age >= age_lim)
            begin
                learn_ivl = learn_ivl + regs.success_step;
                learn_ok_cnt = '0;
                learn_stable = 1'b0;
                learn_fail_cnt = '0;
                note_act = akiu_pkg::ACT_RECALC;
                note_flag = 1'b0;
                change_time = now;
            end
            return;
        end
        if (ok)
        begin
            // Raise the interval after enough successes
            if (learn_ok_cnt >= regs.base_success_count)
            begin
                learn_ok_cnt = '0;
                if (learn_ivl >= top)
                begin
                    learn_ivl = top;
                    learn_stable = 1'b1;
                    learn_mode = doze_wins() ? akiu_pkg::MODE_DOZE : akiu_pkg::MODE_SMART;
                    note_act = akiu_pkg::ACT_CALC_END;
                    note_flag = 1'b0;
                end
                else if (doze_wins())
                    learn_ivl = top;
                else
                begin
                    raised = {1'b0, learn_ivl} + {1'b0, regs.heart_step};
                    learn_ivl = (raised < {1'b0, top}) ? raised[21:0] : top;
                end
            end
        end
        else
        begin
            if (cur_ivl == regs.min_interval)
                return;
            // Back off after enough failures, compared as signed
            if (learn_fail_cnt >= regs.max_fail_count)
            begin
                if (learn_stable)
                begin
                    learn_ivl = regs.min_interval;
                    learn_ok_cnt = '0;
                    learn_stable = 1'b0;
                    note_act = akiu_pkg::ACT_RECALC;
                    note_flag = 1'b1;
                    learn_fail_cnt = '0;
                end
                else
                begin
                    trimmed = learn_ivl;
                    part = regs.heart_step;
                    trimmed = trimmed - part;
                    part = regs.success_step;
                    trimmed = trimmed - part;
                    floor_v = regs.min_interval;
                    if (!doze_wins() && trimmed > floor_v)
                        learn_ivl = 22'(trimmed);
                    else
                        learn_ivl = regs.min_interval;
                    learn_ok_cnt = '0;
                    learn_fail_cnt = '0;
                    learn_stable = 1'b1;
                    learn_mode = doze_wins() ? akiu_pkg::MODE_DOZE : akiu_pkg::MODE_SMART;
                    note_act = akiu_pkg::ACT_CALC_END;
                    note_flag = 1'b0;
                end
            end
        end
        change_time = now;
    endfunction

    // Advance the learner by one event and return the outcome it reports
    function automatic akiu_pkg::result_t learner_step(akiu_pkg::item_t ev);
        akiu_pkg::result_t res;
        longint            lag;
        longint            part;
        note_act = akiu_pkg::ACT_NONE;
        note_flag = 1'b0;
        case (ev.req_type)
            akiu_pkg::REQ_PROBE_SENT:
            begin
                probe_armed = 1'b1;
                wait_resp = 1'b1;
            end
            akiu_pkg::REQ_RESULT:
                settle_probe(ev.success, ev.timed_out, ev.now_seconds, ev.net_connected);
            akiu_pkg::REQ_INTERVAL:
            begin
                if (ev.app_active || link_ok_cnt < regs.stable_test_count)
                    cur_ivl = regs.min_interval;
                else
                begin
                    cur_ivl = learn_ivl;
                    if (doze_wins() && learn_mode != akiu_pkg::MODE_DOZE &&
                        cur_ivl != ivl_ceiling())
                    begin
                        learn_ivl = regs.min_interval;
                        cur_ivl = regs.min_interval;
                    end
                    if (cur_ivl >= regs.max_interval || cur_ivl < regs.min_interval)
                    begin
                        learn_ivl = regs.min_interval;
                        cur_ivl = regs.min_interval;
                    end
                end
            end
            akiu_pkg::REQ_LINK_UP:
            begin
                link_ok_cnt = '0;
                prev_ivl = regs.min_interval;
                cyc_ivl = regs.min_interval;
            end
            akiu_pkg::REQ_LINK_DOWN:
            begin
                settle_probe(1'b0, 1'b0, ev.now_seconds, ev.net_connected);
                learn_ok_cnt = '0;
                if (learn_stable)
                    cur_ivl = regs.min_interval;
            end
            akiu_pkg::REQ_DOZE_CHECK:
            begin
                // Vote on how far the probe drifted from its interval
                if (!ev.app_active && probe_armed && ev.on_mobile)
                begin
                    lag = ev.elapsed_ms;
                    part = cur_ivl;
                    lag = lag - part;
                    if (lag < 0)
                        lag = -lag;
                    if (lag >= DOZE_SLACK_MS)
                    begin
                        doze_cnt = sat_inc(doze_cnt);
                        if (normal_cnt != 0)
                            normal_cnt = normal_cnt - 8'd1;
                    end
                    else
                    begin
                        normal_cnt = sat_inc(normal_cnt);
                        if (doze_cnt != 0)
                            doze_cnt = doze_cnt - 8'd1;
                    end
                    probe_armed = 1'b0;
                end
            end
            default:
                ;
        endcase
        res.interval = cur_ivl;
        res.report_action = note_act;
        res.report_flag = note_flag;
        res.stable = learn_stable;
        res.heart_mode = learn_mode;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // Throttle the result side on a rotating pattern
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            case ($urandom_range(0, 3))
                0: stall_pat = '1;
                1: stall_pat = $urandom();
                2: stall_pat = $urandom() | $urandom();
                default: stall_pat = $urandom() & $urandom();
            endcase
            stall_left = $urandom_range(16, 80);
        end
        else
            stall_left--;
        m_axis_tready = stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[31:1]};
    end

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Compare each result transfer with the oldest outcome still due
    always @(posedge clk)
    begin : check_results
        akiu_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (due_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %h",
                         $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = due_outcomes.pop_front();
                compare_field("interval", 32'(want.interval), 32'(m_axis_tdata[21:0]));
                compare_field("report_action", 32'(want.report_action),
                              32'(m_axis_tdata[24:22]));
                compare_field("report_flag", 32'(want.report_flag),
                              32'(m_axis_tdata[25]));
                compare_field("stable", 32'(want.stable), 32'(m_axis_tdata[26]));
                compare_field("heart_mode", 32'(want.heart_mode),
                              32'(m_axis_tdata[28:27]));
            end
        end
    end

    // Stop a run that hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Event side
    // ------------------------------------------------------------------------

    function automatic akiu_pkg::item_t rand_event(logic [2:0] kind);
        akiu_pkg::item_t ev;
        ev.req_type = kind;
        ev.success = 1'($urandom_range(0, 1));
        ev.timed_out = 1'($urandom_range(0, 1));
        ev.now_seconds = $urandom();
        ev.app_active = 1'($urandom_range(0, 1));
        ev.net_connected = 1'($urandom_range(0, 1));
        ev.on_mobile = 1'($urandom_range(0, 1));
        ev.elapsed_ms = $urandom();
        return ev;
    endfunction

    // Send one event transfer; usually open a gap between bursts
    task automatic post_event(akiu_pkg::item_t ev);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_axis_tuser = ev.req_type;
        s_axis_tdata = {3'b000, ev.elapsed_ms, ev.on_mobile, ev.net_connected,
                        ev.app_active, ev.now_seconds, ev.timed_out, ev.success};
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        due_outcomes.push_back(learner_step(ev));
        events_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    // Hold off new events until every outcome has arrived
    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (due_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_reg(akiu_pkg::reg_idx_t idx, logic [31:0] value);
        cfg_addr = idx;
        cfg_data = value;
        cfg_we = 1'b1;
        @(posedge clk);
        case (idx)
            akiu_pkg::REG_MIN_INTERVAL: regs.min_interval = value[21:0];
            akiu_pkg::REG_MAX_INTERVAL: regs.max_interval = value[21:0];
            akiu_pkg::REG_SUCCESS_STEP: regs.success_step = value[21:0];
            akiu_pkg::REG_HEART_STEP:   regs.heart_step = value[21:0];
            akiu_pkg::REG_STABLE_TEST:  regs.stable_test_count = value[7:0];
            akiu_pkg::REG_BASE_SUCCESS: regs.base_success_count = value[7:0];
            akiu_pkg::REG_MAX_FAIL:     regs.max_fail_count = value[7:0];
            default:                    regs.probe_age_seconds = value;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_regs(logic [31:0] min_v, logic [31:0] max_v, logic [31:0] step_v,
                             logic [31:0] heart_v, logic [31:0] stable_v,
                             logic [31:0] base_v, logic [31:0] fail_v, logic [31:0] age_v);
        drain_results();
        set_reg(akiu_pkg::REG_MIN_INTERVAL, min_v);
        set_reg(akiu_pkg::REG_MAX_INTERVAL, max_v);
        set_reg(akiu_pkg::REG_SUCCESS_STEP, step_v);
        set_reg(akiu_pkg::REG_HEART_STEP, heart_v);
        set_reg(akiu_pkg::REG_STABLE_TEST, stable_v);
        set_reg(akiu_pkg::REG_BASE_SUCCESS, base_v);
        set_reg(akiu_pkg::REG_MAX_FAIL, fail_v);
        set_reg(akiu_pkg::REG_PROBE_AGE, age_v);
    endtask

    // Bring a link up and run probe rounds over it, with some noise
    task automatic link_session(int unsigned rounds, int unsigned fail_pct,
                                int unsigned doze_pct);
        akiu_pkg::item_t ev;
        int unsigned     r;
        post_event(rand_event(akiu_pkg::REQ_LINK_UP));
        repeat (rounds)
        begin
            // Ask for the next interval, mostly from the background
            ev = rand_event(akiu_pkg::REQ_INTERVAL);
            ev.app_active = ($urandom_range(0, 9) == 0);
            post_event(ev);
            post_event(rand_event(akiu_pkg::REQ_PROBE_SENT));
            // Report when the probe really fired
            if ($urandom_range(0, 99) < 60)
            begin
                ev = rand_event(akiu_pkg::REQ_DOZE_CHECK);
                ev.app_active = ($urandom_range(0, 15) == 0);
                ev.on_mobile = ($urandom_range(0, 7) != 0);
                r = $urandom_range(0, 99);
                if (r < doze_pct)
                    ev.elapsed_ms = 32'(cur_ivl) + $urandom_range(20000, 600000);
                else if (r < 92)
                    ev.elapsed_ms = 32'(cur_ivl) + 32'(int'($urandom_range(0, 40000)) - 20000);
                post_event(ev);
            end
            // Move the wall clock, now and then backward or past the probe age
            r = $urandom_range(0, 99);
            if (r < 4)
                clock_s = clock_s - $urandom_range(1, 5000);
            else if (r < 12)
                clock_s = clock_s + regs.probe_age_seconds + $urandom_range(0, 3);
            else
                clock_s = clock_s + $urandom_range(0, 2000);
            ev = rand_event(akiu_pkg::REQ_RESULT);
            ev.success = ($urandom_range(0, 99) >= fail_pct);
            ev.now_seconds = clock_s;
            ev.net_connected = ($urandom_range(0, 7) != 0);
            post_event(ev);
            // Noise: drops, stray events and reconnects
            r = $urandom_range(0, 99);
            if (r < 3)
                post_event(rand_event(akiu_pkg::REQ_LINK_DOWN));
            else if (r < 6)
                post_event(rand_event(3'($urandom_range(0, 7))));
            else if (r < 7)
                post_event(rand_event(akiu_pkg::REQ_LINK_UP));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes, every event code and the corner cases at reset values
    task automatic test_directed_events();
        akiu_pkg::item_t ev;
        ev = '1;
        ev.req_type = REQ_SPARE_A;
        post_event(ev);
        ev = '0;
        ev.req_type = REQ_SPARE_B;
        post_event(ev);
        // Result with no probe outstanding
        post_event(rand_event(akiu_pkg::REQ_RESULT));
        ev = rand_event(akiu_pkg::REQ_INTERVAL);
        ev.app_active = 1'b1;
        post_event(ev);
        ev.app_active = 1'b0;
        post_event(ev);
        // Doze check with no probe fired
        ev = rand_event(akiu_pkg::REQ_DOZE_CHECK);
        ev.app_active = 1'b0;
        ev.on_mobile = 1'b1;
        post_event(ev);
        post_event(rand_event(akiu_pkg::REQ_PROBE_SENT));
        ev.elapsed_ms = '1;
        post_event(ev);
        post_event(rand_event(akiu_pkg::REQ_PROBE_SENT));
        ev = rand_event(akiu_pkg::REQ_RESULT);
        ev.success = 1'b0;
        ev.timed_out = 1'b1;
        ev.now_seconds = '1;
        ev.net_connected = 1'b1;
        post_event(ev);
        ev = rand_event(akiu_pkg::REQ_LINK_DOWN);
        ev.now_seconds = '0;
        post_event(ev);
        post_event(rand_event(akiu_pkg::REQ_LINK_UP));
        post_event(rand_event(akiu_pkg::REQ_PROBE_SENT));
        ev = rand_event(akiu_pkg::REQ_DOZE_CHECK);
        ev.app_active = 1'b0;
        ev.on_mobile = 1'b1;
        ev.elapsed_ms = '0;
        post_event(ev);
        ev = rand_event(akiu_pkg::REQ_RESULT);
        ev.success = 1'b1;
        ev.now_seconds = '0;
        post_event(ev);
        // A run of failures on a young link flags a bad network
        repeat (BAD_NET_RUN)
        begin
            post_event(rand_event(akiu_pkg::REQ_PROBE_SENT));
            ev = rand_event(akiu_pkg::REQ_RESULT);
            ev.success = 1'b0;
            ev.net_connected = 1'b1;
            post_event(ev);
        end
        drain_results();
    endtask

    // Learn up to the ceiling at reset values, then fail and doze
    task automatic test_default_learning();
        link_session(130, 0, 0);
        link_session(30, 35, 0);
        link_session(20, 10, 70);
        drain_results();
    endtask

    // Small values so that learning, back-off and probing turn over quickly
    task automatic test_fast_config();
        load_regs(1000, 60000, 5000, 15000, 1, 1, 1, 100);
        link_session(25, 0, 0);
        link_session(25, 40, 30);
        link_session(25, 80, 0);
        drain_results();
    endtask

    task automatic test_extreme_config();
        // Zero counts, zero ceiling
        load_regs(0, 32'h3FFFFF, 32'h3FFFFF, 32'h3FFFFF, 0, 0, 0, 0);
        link_session(20, 30, 30);
        // Floor above the maximum and saturated counts
        load_regs(32'h3FFFFF, 0, 0, 0, 32'hFF, 32'hFF, 32'hFF, 32'hFFFFFFFF);
        link_session(15, 50, 50);
        // Full-range steps that clamp at the ceiling
        load_regs(0, 32'h3FFFFF, 0, 32'h3FFFFF, 0, 0, 0, 0);
        link_session(20, 20, 10);
        drain_results();
    endtask

    task automatic test_random_config();
        int unsigned phases;
        logic [31:0] lo;
        phases = 0;
        while (events_sent < ITEM_TARGET || phases < 2)
        begin
            if ($urandom_range(0, 9) == 0)
                load_regs($urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom(), $urandom(), $urandom());
            else
            begin
                lo = $urandom_range(0, 400000);
                load_regs(lo, lo + $urandom_range(0, 1500000), $urandom_range(0, 60000),
                          $urandom_range(0, 300000), $urandom_range(0, 6),
                          $urandom_range(0, 5), $urandom_range(0, 5),
                          $urandom_range(0, 2000));
            end
            link_session($urandom_range(15, 50), $urandom_range(0, 70),
                         $urandom_range(0, 60));
            phases++;
        end
        drain_results();
    endtask

    initial
    begin
        // Model state after reset
        regs.min_interval = MIN_IVL_INIT;
        regs.max_interval = MAX_IVL_INIT;
        regs.success_step = SUCCESS_INIT;
        regs.heart_step = HEART_INIT;
        regs.stable_test_count = COUNT_INIT;
        regs.base_success_count = COUNT_INIT;
        regs.max_fail_count = COUNT_INIT;
        regs.probe_age_seconds = PROBE_AGE_INIT;
        wait_resp = 1'b0;
        link_ok_cnt = '0;
        cur_ivl = MIN_IVL_INIT;
        prev_ivl = MIN_IVL_INIT;
        cyc_ivl = MIN_IVL_INIT;
        learn_ivl = MIN_IVL_INIT;
        learn_ok_cnt = '0;
        learn_fail_cnt = '0;
        short_fail_cnt = '0;
        learn_stable = 1'b0;
        learn_mode = akiu_pkg::MODE_NONE;
        change_time = '0;
        doze_cnt = '0;
        normal_cnt = '0;
        probe_armed = 1'b0;

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_events();
        test_default_learning();
        test_fast_config();
        test_extreme_config();
        test_random_config();

        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/akiu_pkg.sv
rtl/akiu_core.sv
rtl/adaptive_keepalive_interval_unit.sv
bench/tb.sv
